>>> src/atl_pkg.sv
// ----------------------------------------------------------------------------
// atl_pkg: shared constants and types of the tint/luminosity color block
// Fixed point constants and the per-word record that rides the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package atl_pkg;

    localparam int unsigned ONE16     = 65536;
    localparam int unsigned MID_MAX   = 58982;   // 0.90 in Q0.16
    localparam int unsigned SUP_WHITE = 29491;   // 0.45
    localparam int unsigned SUP_BLACK = 3277;    // 0.05
    localparam int unsigned V_LOW     = 8192;    // 0.125
    localparam int unsigned V_HIGH    = 63242;   // 0.965
    localparam int unsigned OP_ONE    = 256;
    localparam int unsigned RECIP100  = 5243;    // 2^19 / 100, rounded up
    localparam int unsigned DIV_LAT   = 3;       // divider register stages

    // configuration register indexes
    localparam logic [1:0] REG_TINT_OPACITY = 2'd0;
    localparam logic [1:0] REG_LUM_OVR_EN   = 2'd1;
    localparam logic [1:0] REG_LUM_OVR_OP   = 2'd2;

    // per-word record carried alongside the arithmetic
    typedef struct packed {
        logic       vld;
        logic [7:0] a;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [8:0] op;      // saturated tint opacity
        logic [7:0] ap;      // alpha scaled by opacity
        logic       ovr;     // luminosity override on
        logic [7:0] ovr_la;  // override luminosity alpha
        logic [7:0] mx;
        logic [7:0] dl;
        logic       hneg;
        logic [2:0] base;
    } t_item;

endpackage
`default_nettype wire

>>> src/atl_div.sv
// ----------------------------------------------------------------------------
// atl_div: pipelined restoring divider
// q = floor(num * 2^17 / den) for num <= den, 18 quotient bits in three
// register stages of six bits each.
// ----------------------------------------------------------------------------
`default_nettype none
module atl_div import atl_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic [7:0]  i_num,
    input  wire logic [7:0]  i_den,
    output logic      [17:0] o_q
);

    // one shift-subtract step: {quotient bit, new remainder}
    function automatic logic [8:0] f_step(input logic [7:0] rem, input logic [7:0] den);
        logic [8:0] r2;
        logic [8:0] df;
        r2 = {rem, 1'b0};
        df = r2 - {1'b0, den};
        if (r2 >= {1'b0, den}) begin
            f_step = {1'b1, df[7:0]};
        end else begin
            f_step = {1'b0, r2[7:0]};
        end
    endfunction

    logic [7:0]  r_rem_a, r_den_a, r_rem_b, r_den_b;
    logic [5:0]  r_qa, r_qa_b;
    logic [5:0]  r_qb;
    logic [17:0] r_q;
    logic [7:0]  n_rem_a, n_rem_b, n_rem_c;
    logic [5:0]  n_qa, n_qb, n_qc;
    logic [8:0]  st_a, st_b, st_c;

    // stage A: integer bit plus five fraction bits
    always_comb begin
        n_qa = '0;
        if (i_num >= i_den) begin
            n_qa[5]  = 1'b1;
            n_rem_a  = i_num - i_den;
        end else begin
            n_rem_a  = i_num;
        end
        for (int i = 4; i >= 0; i--) begin
            st_a     = f_step(n_rem_a, i_den);
            n_qa[i]  = st_a[8];
            n_rem_a  = st_a[7:0];
        end
    end

    // stage B
    always_comb begin
        n_qb    = '0;
        n_rem_b = r_rem_a;
        for (int i = 5; i >= 0; i--) begin
            st_b    = f_step(n_rem_b, r_den_a);
            n_qb[i] = st_b[8];
            n_rem_b = st_b[7:0];
        end
    end

    // stage C
    always_comb begin
        n_qc    = '0;
        n_rem_c = r_rem_b;
        for (int i = 5; i >= 0; i--) begin
            st_c    = f_step(n_rem_c, r_den_b);
            n_qc[i] = st_c[8];
            n_rem_c = st_c[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem_a <= n_rem_a;
        r_den_a <= i_den;
        r_qa    <= n_qa;
        r_rem_b <= n_rem_b;
        r_den_b <= r_den_a;
        r_qa_b  <= r_qa;
        r_qb    <= n_qb;
        r_q     <= {r_qa_b, r_qb, n_qc};
    end

    assign o_q = r_q;

endmodule
`default_nettype wire

>>> src/acrylic_tint_luminosity_color.sv
// ----------------------------------------------------------------------------
// acrylic_tint_luminosity_color: tint and luminosity color mapping
// One ARGB tint word in, one effective tint plus one luminosity color out.
// ----------------------------------------------------------------------------
// A word is taken whenever i_start is high (o_busy is always low) and its
// result appears with o_valid, one word per cycle sustained. The pipeline
// holds the two pipelined 18-bit dividers (saturation and hue fraction,
// three stages) plus the multiply chain of the opacity modifier. Results
// cannot be held off by the receiver; the configuration registers should
// be written only while no word is in flight.
`default_nettype none
module acrylic_tint_luminosity_color import atl_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    output logic            o_busy,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_idx,
    input  wire logic [8:0] i_cfg_wdata,
    input  wire logic [7:0] i_tint_alpha,
    input  wire logic [7:0] i_tint_red,
    input  wire logic [7:0] i_tint_green,
    input  wire logic [7:0] i_tint_blue,
    output logic            o_valid,
    output logic [7:0]      o_eff_alpha,
    output logic [7:0]      o_eff_red,
    output logic [7:0]      o_eff_green,
    output logic [7:0]      o_eff_blue,
    output logic [7:0]      o_lum_alpha,
    output logic [7:0]      o_lum_red,
    output logic [7:0]      o_lum_green,
    output logic [7:0]      o_lum_blue
);

    assign o_busy = 1'b0;

    // configuration registers
    logic [8:0] r_tint_op, r_ovr_op;
    logic       r_ovr_en;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tint_op <= 9'(OP_ONE);
            r_ovr_en  <= 1'b0;
            r_ovr_op  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TINT_OPACITY: r_tint_op <= i_cfg_wdata;
                REG_LUM_OVR_EN:   r_ovr_en  <= i_cfg_wdata[0];
                REG_LUM_OVR_OP:   r_ovr_op  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------- S1: min/max, hue operands, scaled alpha ----------------
    t_item      n_s1, r_s1;
    logic [8:0] op, ovo;
    logic [16:0] aop_rnd;
    logic [16:0] ovr_rnd;
    logic [7:0] mx, mn, pos, neg;
    logic [7:0] r_hnum;
    logic [7:0] hnum;
    always_comb begin
        op      = (r_tint_op > 9'(OP_ONE)) ? 9'(OP_ONE) : r_tint_op;
        ovo     = (r_ovr_op  > 9'(OP_ONE)) ? 9'(OP_ONE) : r_ovr_op;
        aop_rnd = 17'(i_tint_alpha * op) + 17'd128;
        ovr_rnd = 17'(ovo * 9'd255) + 17'd128;
        mx = (i_tint_red > i_tint_green) ? i_tint_red : i_tint_green;
        mx = (mx > i_tint_blue) ? mx : i_tint_blue;
        mn = (i_tint_red < i_tint_green) ? i_tint_red : i_tint_green;
        mn = (mn < i_tint_blue) ? mn : i_tint_blue;
        n_s1.vld    = i_start;
        n_s1.a      = i_tint_alpha;
        n_s1.r      = i_tint_red;
        n_s1.g      = i_tint_green;
        n_s1.b      = i_tint_blue;
        n_s1.op     = op;
        n_s1.ap     = (aop_rnd[16:8] > 9'd255) ? 8'd255 : aop_rnd[15:8];
        n_s1.ovr    = r_ovr_en;
        n_s1.ovr_la = ovr_rnd[15:8];
        n_s1.mx     = mx;
        n_s1.dl     = mx - mn;
        if (mx == i_tint_red) begin
            n_s1.base = 3'd0; pos = i_tint_green; neg = i_tint_blue;
        end else if (mx == i_tint_green) begin
            n_s1.base = 3'd2; pos = i_tint_blue;  neg = i_tint_red;
        end else begin
            n_s1.base = 3'd4; pos = i_tint_red;   neg = i_tint_green;
        end
        n_s1.hneg = (pos < neg);
        hnum      = n_s1.hneg ? (neg - pos) : (pos - neg);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.vld <= 1'b0;
        end else begin
            r_s1.vld <= n_s1.vld;
        end
        r_s1.a      <= n_s1.a;
        r_s1.r      <= n_s1.r;
        r_s1.g      <= n_s1.g;
        r_s1.b      <= n_s1.b;
        r_s1.op     <= n_s1.op;
        r_s1.ap     <= n_s1.ap;
        r_s1.ovr    <= n_s1.ovr;
        r_s1.ovr_la <= n_s1.ovr_la;
        r_s1.mx     <= n_s1.mx;
        r_s1.dl     <= n_s1.dl;
        r_s1.hneg   <= n_s1.hneg;
        r_s1.base   <= n_s1.base;
        r_hnum      <= hnum;
    end

    // ---------------- S2..S4: saturation and hue dividers ----------------
    logic [17:0] q_s, q_h;
    atl_div u_div_sat (.i_clk(i_clk), .i_num(r_s1.dl), .i_den(r_s1.mx), .o_q(q_s));
    atl_div u_div_hue (.i_clk(i_clk), .i_num(r_hnum),  .i_den(r_s1.dl), .o_q(q_h));

    t_item r_dly [DIV_LAT];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIV_LAT; i++) begin
                r_dly[i] <= '0;
            end
        end else begin
            r_dly[0] <= r_s1;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_dly[i] <= r_dly[i-1];
            end
        end
    end

    // ---------------- S5: HSV terms ----------------
    t_item       d4;
    logic [16:0] s, hq, frac, fp, v, dv, f;
    logic [2:0]  sec;
    logic [15:0] vcl;
    logic        light;
    logic [7:0]  dev;
    logic [17:0] q_s_r, q_h_r, s2;
    always_comb begin
        d4    = r_dly[DIV_LAT-1];
        q_s_r = q_s + 18'd1;
        q_h_r = q_h + 18'd1;
        s     = (d4.mx == 8'd0) ? 17'd0 : q_s_r[17:1];
        hq    = q_h_r[17:1];
        sec   = 3'd0;
        frac  = 17'd0;
        if (d4.dl != 8'd0) begin
            if (!d4.hneg) begin
                sec  = d4.base;
                frac = hq;
            end else begin
                case (d4.base)
                    3'd0:    sec = 3'd5;
                    3'd2:    sec = 3'd1;
                    default: sec = 3'd3;
                endcase
                frac = 17'(ONE16) - hq;
            end
            if (frac >= 17'(ONE16)) begin
                frac = 17'd0;
                sec  = sec + 3'd1;
            end
        end
        fp    = sec[0] ? (17'(ONE16) - frac) : frac;
        v     = 17'(d4.mx * 9'd257) + {16'd0, d4.mx[7]};
        if (v < 17'(V_LOW)) begin
            vcl = 16'(V_LOW);
        end else if (v > 17'(V_HIGH)) begin
            vcl = 16'(V_HIGH);
        end else begin
            vcl = v[15:0];
        end
        light = d4.mx[7];
        dev   = light ? 8'({d4.mx, 1'b0} - 9'd255) : 8'(9'd255 - {d4.mx, 1'b0});
        dv    = 17'(dev * 9'd257) + {16'd0, dev[7]};
        s2    = {s, 1'b0};
        f     = (s2 >= 18'(ONE16)) ? 17'd0 : 17'(18'(ONE16) - s2);
    end

    t_item       r_s5;
    logic [16:0] r5_s, r5_fp, r5_d, r5_f;
    logic [15:0] r5_v;
    logic [2:0]  r5_sec;
    logic        r5_light;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s5 <= '0;
        else          r_s5 <= d4;
        r5_s     <= s;
        r5_fp    <= fp;
        r5_d     <= dv;
        r5_f     <= f;
        r5_v     <= vcl;
        r5_sec   <= sec;
        r5_light <= light;
    end

    // ---------------- S6: f*d, chroma, a*op, alpha numerator ----------------
    logic [32:0] c_raw;
    logic [32:0] c_rnd;
    t_item       r_s6;
    logic [33:0] r6_t1;
    logic [15:0] r6_c, r6_v;
    logic [16:0] r6_fp, r6_aop;
    logic [14:0] r6_y;
    logic [2:0]  r6_sec;
    logic        r6_light;
    always_comb begin
        c_raw = r5_v * r5_s;
        c_rnd = c_raw + 33'd32768;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s6 <= '0;
        else          r_s6 <= r_s5;
        r6_t1    <= r5_f * r5_d;
        r6_c     <= c_rnd[31:16];
        r6_v     <= r5_v;
        r6_fp    <= r5_fp;
        r6_aop   <= 17'(r_s5.a * r_s5.op);
        r6_y     <= 15'(r_s5.ap * 7'd88) + 15'd3875;
        r6_sec   <= r5_sec;
        r6_light <= r5_light;
    end

    // ---------------- S7: modifier product, x product, m ----------------
    logic [14:0] sup;
    logic [28:0] y_mul;
    logic [9:0]  la_q;
    t_item       r_s7;
    logic [48:0] r7_p;
    logic [32:0] r7_x;
    logic [15:0] r7_c, r7_m;
    logic [16:0] r7_aop;
    logic [7:0]  r7_la;
    logic [2:0]  r7_sec;
    always_comb begin
        sup   = r6_light ? 15'(SUP_WHITE) : 15'(SUP_BLACK);
        y_mul = r6_y * 14'(RECIP100);
        la_q  = y_mul[28:19];
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s7 <= '0;
        else          r_s7 <= r_s6;
        r7_p   <= sup * r6_t1;
        r7_x   <= r6_c * r6_fp;
        r7_c   <= r6_c;
        r7_m   <= r6_v - r6_c;
        r7_aop <= r6_aop;
        r7_la  <= (la_q > 10'd255) ? 8'd255 : la_q[7:0];
        r7_sec <= r6_sec;
    end

    // ---------------- S8: modifier, channel sums ----------------
    logic [48:0] p_rnd;
    logic [32:0] x_rnd;
    logic [15:0] x;
    logic [16:0] cc, xx, mm, sr, sg, sb;
    t_item       r_s8;
    logic [15:0] r8_mod;
    logic [16:0] r8_aop, r8_sr, r8_sg, r8_sb;
    logic [7:0]  r8_la;
    always_comb begin
        p_rnd = r7_p + 49'h0_8000_0000;
        x_rnd = r7_x + 33'd32768;
        x     = x_rnd[31:16];
        cc    = {1'b0, r7_c};
        xx    = {1'b0, x};
        mm    = {1'b0, r7_m};
        case (r7_sec)
            3'd0:    begin sr = cc;    sg = xx;    sb = 17'd0; end
            3'd1:    begin sr = xx;    sg = cc;    sb = 17'd0; end
            3'd2:    begin sr = 17'd0; sg = cc;    sb = xx;    end
            3'd3:    begin sr = 17'd0; sg = xx;    sb = cc;    end
            3'd4:    begin sr = xx;    sg = 17'd0; sb = cc;    end
            default: begin sr = cc;    sg = 17'd0; sb = xx;    end
        endcase
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s8 <= '0;
        else          r_s8 <= r_s7;
        r8_mod <= 16'(MID_MAX) - 16'(p_rnd[48:32]);
        r8_aop <= r7_aop;
        r8_sr  <= sr + mm;
        r8_sg  <= sg + mm;
        r8_sb  <= sb + mm;
        r8_la  <= r7_la;
    end

    // ---------------- S9: alpha product, channel scaling ----------------
    function automatic logic [7:0] f_chan(input logic [16:0] x16);
        logic [25:0] t;
        t = 26'(x16 * 8'd255) + 26'd32768;
        f_chan = (t[25:16] > 10'd255) ? 8'd255 : t[23:16];
    endfunction

    t_item       r_s9;
    logic [32:0] r9_ea;
    logic [7:0]  r9_r, r9_g, r9_b, r9_la;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s9 <= '0;
        else          r_s9 <= r_s8;
        r9_ea <= r8_aop * r8_mod;
        r9_r  <= f_chan(r8_sr);
        r9_g  <= f_chan(r8_sg);
        r9_b  <= f_chan(r8_sb);
        r9_la <= r8_la;
    end

    // ---------------- S10: output register ----------------
    logic [32:0] ea_rnd;
    always_comb begin
        ea_rnd = r9_ea + 33'h80_0000;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_s9.vld;
        end
        o_eff_red   <= r_s9.r;
        o_eff_green <= r_s9.g;
        o_eff_blue  <= r_s9.b;
        if (r_s9.ovr) begin
            o_eff_alpha <= r_s9.ap;
            o_lum_alpha <= r_s9.ovr_la;
            o_lum_red   <= r_s9.r;
            o_lum_green <= r_s9.g;
            o_lum_blue  <= r_s9.b;
        end else begin
            o_eff_alpha <= (ea_rnd[32:24] > 9'd255) ? 8'd255 : ea_rnd[31:24];
            o_lum_alpha <= r9_la;
            o_lum_red   <= r9_r;
            o_lum_green <= r9_g;
            o_lum_blue  <= r9_b;
        end
    end

endmodule
`default_nettype wire

>>> dv/tb_acrylic_tint_luminosity_color.sv
// ----------------------------------------------------------------------------
// tb_acrylic_tint_luminosity_color: self-checking bench of the tint block
// Directed table then random bursts; every word is checked field by field
// against a fixed point predictor, with register settings changed between
// phases while the pipeline is empty.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_acrylic_tint_luminosity_color;
    import atl_pkg::*;

    localparam int PIPE_LAT = 10;
    localparam int WDOG_MAX = 2000;

    typedef struct packed {
        logic [7:0] ea, er, eg, eb, la, lr, lg, lb;
    } t_colors;

    // one row of the directed table; chk says the typed-in result holds
    typedef struct {
        logic [7:0] a, r, g, b;
        bit         chk;
        t_colors    res;
    } t_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_start = 1'b0;
    logic       o_busy;
    logic       i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = REG_TINT_OPACITY;
    logic [8:0] i_cfg_wdata = '0;
    logic [7:0] i_tint_alpha = '0, i_tint_red = '0, i_tint_green = '0, i_tint_blue = '0;
    logic       o_valid;
    logic [7:0] o_eff_alpha, o_eff_red, o_eff_green, o_eff_blue;
    logic [7:0] o_lum_alpha, o_lum_red, o_lum_green, o_lum_blue;

    int unsigned cur_op = 256, cur_ovr = 0, cur_ovr_op = 0;
    t_colors     expected_q[$];
    int          n_err = 0;
    int          idle_cycles = 0;

    acrylic_tint_luminosity_color i_dut (.*);

    always #4 i_clk = ~i_clk;

    // ---------------- predictor ----------------
    function automatic longint unsigned rnd_div(longint unsigned n, longint unsigned d);
        return (n + d / 2) / d;
    endfunction

    function automatic int unsigned to_chan(longint unsigned x16);
        longint unsigned c;
        c = rnd_div(x16 * 255, ONE16);
        return (c > 255) ? 255 : int'(c);
    endfunction

    function automatic t_colors map_tint(int unsigned a, int unsigned r, int unsigned g,
                                         int unsigned b);
        t_colors         o;
        int unsigned     op, ap, ea, la, mx, mn, dl, s, sup, dev, sector, frac;
        int unsigned     base, pos, neg, v, c, fp, x, m, rr, gg, bb;
        longint unsigned f, dd, p, md;
        op = (cur_op > OP_ONE) ? OP_ONE : cur_op;
        ap = (a * op + 128) >> 8;
        if (ap > 255) ap = 255;
        mx = (r > g) ? r : g; mx = (mx > b) ? mx : b;
        mn = (r < g) ? r : g; mn = (mn < b) ? mn : b;
        dl = mx - mn;
        s  = (mx != 0) ? int'(rnd_div(longint'(dl) * ONE16, mx)) : 0;
        if (cur_ovr != 0) begin
            ea = ap;
            la = (((cur_ovr_op > OP_ONE) ? OP_ONE : cur_ovr_op) * 255 + 128) >> 8;
            rr = r; gg = g; bb = b;
        end else begin
            // opacity modifier from value and saturation
            sup = (2 * mx > 255) ? SUP_WHITE : SUP_BLACK;
            f   = (2 * s >= ONE16) ? 0 : ONE16 - 2 * s;
            dev = (2 * mx > 255) ? 2 * mx - 255 : 255 - 2 * mx;
            dd  = rnd_div(longint'(dev) * ONE16, 255);
            p   = (longint'(sup) * f * dd + 64'h8000_0000) >> 32;
            md  = MID_MAX - p;
            ea  = int'((longint'(a) * op * md + 64'h80_0000) >> 24);
            la  = (88 * ap + 3825 + 50) / 100;
            // hue sector and fraction
            sector = 0; frac = 0;
            if (dl != 0) begin
                if (mx == r) begin base = 0; pos = g; neg = b; end
                else if (mx == g) begin base = 2; pos = b; neg = r; end
                else begin base = 4; pos = r; neg = g; end
                if (pos >= neg) begin
                    sector = base;
                    frac = int'(rnd_div(longint'(pos - neg) * ONE16, dl));
                end else begin
                    sector = (base + 5) % 6;
                    frac = ONE16 - int'(rnd_div(longint'(neg - pos) * ONE16, dl));
                end
                if (frac >= ONE16) begin frac = 0; sector = (sector + 1) % 6; end
            end
            // clamp V and convert back
            v = int'(rnd_div(longint'(mx) * ONE16, 255));
            if (v < V_LOW) v = V_LOW;
            if (v > V_HIGH) v = V_HIGH;
            c  = int'(rnd_div(longint'(v) * s, ONE16));
            fp = sector[0] ? ONE16 - frac : frac;
            x  = int'(rnd_div(longint'(c) * fp, ONE16));
            m  = v - c;
            case (sector)
                0: begin rr = c; gg = x; bb = 0; end
                1: begin rr = x; gg = c; bb = 0; end
                2: begin rr = 0; gg = c; bb = x; end
                3: begin rr = 0; gg = x; bb = c; end
                4: begin rr = x; gg = 0; bb = c; end
                default: begin rr = c; gg = 0; bb = x; end
            endcase
            rr = to_chan(rr + m); gg = to_chan(gg + m); bb = to_chan(bb + m);
        end
        if (ea > 255) ea = 255;
        if (la > 255) la = 255;
        o = '{ea[7:0], r[7:0], g[7:0], b[7:0], la[7:0], rr[7:0], gg[7:0], bb[7:0]};
        return o;
    endfunction

    // ---------------- result checking ----------------
    always @(posedge i_clk) begin
        t_colors got, want;
        if (i_rst_n && o_valid) begin
            got = '{o_eff_alpha, o_eff_red, o_eff_green, o_eff_blue,
                    o_lum_alpha, o_lum_red, o_lum_green, o_lum_blue};
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected word %h", $time, got);
                n_err++;
            end else begin
                want = expected_q.pop_front();
                if (got.ea !== want.ea) begin $display("%0t: eff_alpha exp %0d got %0d", $time, want.ea, got.ea); n_err++; end
                if (got.er !== want.er) begin $display("%0t: eff_red exp %0d got %0d", $time, want.er, got.er); n_err++; end
                if (got.eg !== want.eg) begin $display("%0t: eff_green exp %0d got %0d", $time, want.eg, got.eg); n_err++; end
                if (got.eb !== want.eb) begin $display("%0t: eff_blue exp %0d got %0d", $time, want.eb, got.eb); n_err++; end
                if (got.la !== want.la) begin $display("%0t: lum_alpha exp %0d got %0d", $time, want.la, got.la); n_err++; end
                if (got.lr !== want.lr) begin $display("%0t: lum_red exp %0d got %0d", $time, want.lr, got.lr); n_err++; end
                if (got.lg !== want.lg) begin $display("%0t: lum_green exp %0d got %0d", $time, want.lg, got.lg); n_err++; end
                if (got.lb !== want.lb) begin $display("%0t: lum_blue exp %0d got %0d", $time, want.lb, got.lb); n_err++; end
            end
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_valid || i_cfg_we) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("status: fail");
            $finish;
        end
    end

    // ---------------- drivers ----------------
    task automatic write_reg(input logic [1:0] idx, input int unsigned val);
        @(negedge i_clk);
        i_cfg_we = 1'b1; i_cfg_idx = idx; i_cfg_wdata = val[8:0];
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            REG_TINT_OPACITY: cur_op = val & 9'h1FF;
            REG_LUM_OVR_EN:   cur_ovr = val & 1;
            default:          cur_ovr_op = val & 9'h1FF;
        endcase
    endtask

    // drive one word at once, hold until accepted, then drop i_start if last
    task automatic send_word(input logic [7:0] a, r, g, b, input bit last);
        i_start = 1'b1;
        i_tint_alpha = a; i_tint_red = r; i_tint_green = g; i_tint_blue = b;
        do @(posedge i_clk); while (o_busy);
        expected_q.push_back(map_tint(a, r, g, b));
        @(negedge i_clk);
        if (last) i_start = 1'b0;
    endtask

    task automatic drain();
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (PIPE_LAT + 2) @(negedge i_clk);
    endtask

    task automatic random_phase(input int n_words);
        int sent, burst, gap;
        sent = 0;
        while (sent < n_words) begin
            burst = $urandom_range(1, 20);
            for (int k = 0; k < burst && sent < n_words; k++) begin
                logic [7:0] a, r, g, b;
                a = 8'($urandom); r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
                // some greys to hit zero delta
                if ($urandom_range(0, 7) == 0) begin g = r; b = r; end
                if ($urandom_range(0, 15) == 0) a = ($urandom_range(0, 1)) ? 8'hFF : 8'h00;
                sent++;
                send_word(a, r, g, b, (k == burst - 1) || (sent == n_words));
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // directed rows; typed-in results only for the plain cases
    t_row dir_tab[] = '{
        '{8'hFF, 8'h00, 8'h00, 8'h00, 1'b0, '0},
        '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, '0},
        '{8'h00, 8'hFF, 8'h00, 8'h00, 1'b0, '0},
        '{8'hFF, 8'h00, 8'hFF, 8'h00, 1'b0, '0},
        '{8'h80, 8'h00, 8'h00, 8'hFF, 1'b0, '0},
        '{8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b0, '0},
        '{8'h7F, 8'h00, 8'hFF, 8'hFF, 1'b0, '0},
        '{8'h01, 8'hFF, 8'h00, 8'hFF, 1'b0, '0},
        '{8'hFF, 8'h80, 8'h80, 8'h80, 1'b0, '0},
        '{8'hAA, 8'h55, 8'hAA, 8'h55, 1'b0, '0},
        '{8'h55, 8'hFF, 8'h01, 8'h00, 1'b0, '0},
        '{8'hFF, 8'hFF, 8'h00, 8'h01, 1'b0, '0},
        '{8'hFF, 8'h7F, 8'h7F, 8'h7F, 1'b0, '0},
        '{8'hFF, 8'h10, 8'h20, 8'h30, 1'b0, '0},
        '{8'h00, 8'h00, 8'h00, 8'h00, 1'b1,
          '{8'd0, 8'd0, 8'd0, 8'd0, 8'd38, 8'd32, 8'd32, 8'd32}}
    };

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part at reset settings
        foreach (dir_tab[i]) begin
            send_word(dir_tab[i].a, dir_tab[i].r, dir_tab[i].g, dir_tab[i].b, 1'b1);
            if (dir_tab[i].chk && map_tint(dir_tab[i].a, dir_tab[i].r, dir_tab[i].g,
                                           dir_tab[i].b) !== dir_tab[i].res) begin
                $display("%0t: table row %0d exp %h got %h", $time, i, dir_tab[i].res,
                         map_tint(dir_tab[i].a, dir_tab[i].r, dir_tab[i].g, dir_tab[i].b));
                n_err++;
            end
        end
        drain();

        // override on, extremes of both opacities, opacity above one
        write_reg(REG_LUM_OVR_EN, 1);
        write_reg(REG_LUM_OVR_OP, 256);
        write_reg(REG_TINT_OPACITY, 511);
        send_word(8'hFF, 8'h12, 8'h34, 8'h56, 1'b1);
        send_word(8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        drain();
        write_reg(REG_LUM_OVR_OP, 0);
        write_reg(REG_TINT_OPACITY, 0);
        send_word(8'hFF, 8'hFF, 8'h00, 8'h00, 1'b1);
        drain();
        write_reg(REG_LUM_OVR_OP, 511);
        send_word(8'h80, 8'h00, 8'h40, 8'hC0, 1'b1);
        drain();

        // random phases over several settings
        write_reg(REG_LUM_OVR_EN, 0);
        write_reg(REG_TINT_OPACITY, 256);
        random_phase(100);
        drain();
        write_reg(REG_TINT_OPACITY, 0);
        random_phase(40);
        drain();
        write_reg(REG_TINT_OPACITY, $urandom_range(257, 511));
        random_phase(40);
        drain();
        write_reg(REG_TINT_OPACITY, $urandom_range(1, 255));
        random_phase(100);
        drain();
        write_reg(REG_LUM_OVR_EN, 1);
        write_reg(REG_LUM_OVR_OP, $urandom_range(0, 511));
        write_reg(REG_TINT_OPACITY, $urandom_range(0, 511));
        random_phase(60);
        drain();
        write_reg(REG_LUM_OVR_EN, 0);
        write_reg(REG_TINT_OPACITY, $urandom_range(0, 511));
        random_phase(60);
        drain();

        if (n_err == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end
endmodule
`default_nettype wire

>>> acrylic_tint_luminosity_color.f
src/atl_pkg.sv
src/atl_div.sv
src/acrylic_tint_luminosity_color.sv
dv/tb_acrylic_tint_luminosity_color.sv
